>>> src/insertion_sorter_core_defines.svh
// Assertion macros shared by the insertion sorter checkers.
`ifndef INSERTION_SORTER_CORE_DEFINES_SVH
`define INSERTION_SORTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ISC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/isort_pkg.sv
// Shared types for the insertion sorter.
`default_nettype none

package isort_pkg;

	// Sequencer states of the sorter core.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_OUT_RD,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

>>> src/isort_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module isort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> src/insertion_sorter_core.sv
// Top level of the stable insertion sorter: sequencer around one sorted RAM.
`default_nettype none

// Stable ascending insertion sorter. An item (value, last) is taken when start
// is high and busy is low. Each value is placed into a sorted RAM by walking
// down from the top entry: every stored entry strictly greater than the value
// moves up one slot, so equal values keep their arrival order. Inserting a
// value writes one slot per entry it passes and then the value itself; a
// value is only stored while fewer than MAX_ITEMS entries are held. The walk
// is bound by the single RAM write port, which moves one entry per cycle. A
// value that arrives with the store full is dropped in the accept cycle and
// flags overflow for the whole run. An item with last set is inserted (or
// dropped) and then the store is read out in ascending order: n results, one
// per cycle after a read warm-up state, strobe high for each, last_res on the
// largest, overflow on all of them if any value was dropped. Results come
// straight off the RAM read register; the receiver has no stall and must take
// each item in its strobe cycle. busy is high from the cycle after an accept
// until the run (or insertion) is done; a full-store drop without last leaves
// it low. The store is emptied after output; RAM contents need no clearing
// since only entries below the fill count are ever read back.

module insertion_sorter_core #(
	parameter int MAX_ITEMS   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input items
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	input  wire logic                          last,
	// result items
	output logic                               strobe,
	output logic signed      [VALUE_WIDTH-1:0] value_res,
	output logic                               last_res,
	output logic                               overflow
);

	localparam int AW = $clog2(MAX_ITEMS);      // RAM address width
	localparam int CW = $clog2(MAX_ITEMS + 1);  // fill count width (holds MAX_ITEMS)

	isort_pkg::state_t state_q, state_nxt;

	logic [CW-1:0]                 count_q;     // entries in the store
	logic                          dropped_q;   // a value of this set was dropped
	logic [CW-1:0]                 pos_q;       // hole position during the walk
	logic [CW-1:0]                 idx_q;       // read-out index
	logic signed [VALUE_WIDTH-1:0] key_q;       // value being inserted
	logic                          last_q;      // inserted item closes the set

	// RAM port
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [VALUE_WIDTH-1:0] ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [VALUE_WIDTH-1:0] ram_rdata;

	logic accept;
	logic full;
	logic key_below;   // key sorts strictly below the entry just read
	logic ins_done;    // insertion walk ends this cycle
	logic out_done;    // last result goes out this cycle

	assign accept    = start && (state_q == isort_pkg::ST_IDLE);
	assign full      = (count_q == CW'(MAX_ITEMS));
	assign key_below = key_q < $signed(ram_rdata);
	assign ins_done  = (state_q == isort_pkg::ST_SHIFT) && ((pos_q == '0) || !key_below);
	assign out_done  = (state_q == isort_pkg::ST_OUT) && (idx_q + CW'(1) == count_q);

	isort_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(MAX_ITEMS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			isort_pkg::ST_IDLE: begin
				if (accept) begin
					if (!full) begin
						state_nxt = isort_pkg::ST_SHIFT;
					end else if (last) begin
						state_nxt = isort_pkg::ST_OUT_RD;
					end
				end
			end
			isort_pkg::ST_SHIFT: begin
				if (ins_done) begin
					state_nxt = last_q ? isort_pkg::ST_OUT_RD : isort_pkg::ST_IDLE;
				end
			end
			isort_pkg::ST_OUT_RD: begin
				state_nxt = isort_pkg::ST_OUT;
			end
			isort_pkg::ST_OUT: begin
				if (out_done) begin
					state_nxt = isort_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = isort_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs and RAM control. The walk reads slot pos-2 while writing slot
	// pos, so a read never hits the entry being written: no forwarding needed.
	always_comb begin
		busy      = 1'b1;
		strobe    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = pos_q[AW-1:0];
		ram_wdata = key_q;
		ram_raddr = '0;
		case (state_q)
			isort_pkg::ST_IDLE: begin
				busy      = 1'b0;
				// top entry, ignored when the store is empty
				ram_raddr = AW'(count_q - CW'(1));
			end
			isort_pkg::ST_SHIFT: begin
				ram_we    = 1'b1;
				ram_raddr = AW'(pos_q - CW'(2));
				if ((pos_q != '0) && key_below) begin
					ram_wdata = ram_rdata;   // move entry up one slot
				end
			end
			isort_pkg::ST_OUT_RD: begin
				ram_raddr = '0;
			end
			isort_pkg::ST_OUT: begin
				strobe    = 1'b1;
				ram_raddr = AW'(idx_q + CW'(1));
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign value_res = ram_rdata;
	assign last_res  = out_done;
	assign overflow  = dropped_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= isort_pkg::ST_IDLE;
			count_q   <= '0;
			dropped_q <= 1'b0;
			pos_q     <= '0;
			idx_q     <= '0;
			last_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				last_q <= last;
				pos_q  <= count_q;
				if (full) begin
					dropped_q <= 1'b1;
				end
			end
			if ((state_q == isort_pkg::ST_SHIFT) && !ins_done) begin
				pos_q <= pos_q - CW'(1);
			end
			if (ins_done) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == isort_pkg::ST_OUT_RD) begin
				idx_q <= '0;
			end else if (state_q == isort_pkg::ST_OUT) begin
				idx_q <= idx_q + CW'(1);
			end
			if (out_done) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= value;
		end
	end

endmodule

`default_nettype wire

>>> src/isort_checker.sv
// Port-level checker for the insertion sorter, bound to the top level.
`default_nettype none
`include "insertion_sorter_core_defines.svh"

module isort_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic busy,
	input wire logic strobe,
	input wire logic last_res,
	input wire logic overflow
);

	`ISC_ASSERT_NOW(a_strobe_busy, clk, arst_n, strobe, busy, "result outside busy window")
	`ISC_ASSERT_NEXT(a_run_contig, clk, arst_n, strobe && !last_res, strobe, "gap inside run")
	`ISC_ASSERT_NEXT(a_ovf_steady, clk, arst_n, strobe && !last_res, overflow == $past(overflow), "overflow changed inside run")
	`ISC_ASSERT_NEXT(a_end_idle, clk, arst_n, strobe && last_res, !busy, "still busy after final result")
	`ISC_ASSERT_NOW(a_run_lead, clk, arst_n, $rose(strobe), $past(busy), "run without read warm-up")

endmodule

bind insertion_sorter_core isort_checker u_isort_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.busy     (busy),
	.strobe   (strobe),
	.last_res (last_res),
	.overflow (overflow)
);

`default_nettype wire

>>> verif/insertion_sorter_core_test.sv
// Self-checking testbench for insertion_sorter_core: directed table plus random sets.
`default_nettype none

module insertion_sorter_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ITEMS   = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int RAND_ITEMS  = 360;

	localparam logic signed [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic signed [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

	// One sorted output item as the block should present it.
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] value;
		logic                          last_res;
		logic                          overflow;
	} sorted_item_t;

	// Row of the directed table. A row marked known carries a lone-item
	// set whose single output can be typed in directly.
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] value;
		logic                          last;
		logic                          known;
		logic signed [VALUE_WIDTH-1:0] known_value;
	} dir_row_t;

	localparam int DIR_ROWS = 21;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                          start = 1'b0;
	logic                          busy;
	logic signed [VALUE_WIDTH-1:0] value = '0;
	logic                          last  = 1'b0;

	logic                          strobe;
	logic signed [VALUE_WIDTH-1:0] value_res;
	logic                          last_res;
	logic                          overflow;

	// Predictor state: the sorted store, its fill and the drop flag.
	logic signed [VALUE_WIDTH-1:0] sort_store [MAX_ITEMS];
	int unsigned                   sort_fill    = 0;
	bit                            sort_dropped = 1'b0;

	sorted_item_t pending_sorted [$];   // outputs still to come, oldest first
	dir_row_t     item_tags      [$];   // per driven item: typed-in output, if any

	int unsigned mismatch_cnt = 0;
	bit          burst        = 1'b0;   // no gaps for the current set

	dir_row_t dir_rows [DIR_ROWS] = '{
		// lone values: the single output is the value itself, last_res set
		'{V_MIN, 1'b1, 1'b1, V_MIN},
		'{V_MAX, 1'b1, 1'b1, V_MAX},
		'{32'sd0, 1'b1, 1'b1, 32'sd0},
		'{-32'sd1, 1'b1, 1'b1, -32'sd1},
		// descending: every value walks to the bottom of the store
		'{32'sd3, 1'b0, 1'b0, '0},
		'{32'sd2, 1'b0, 1'b0, '0},
		'{32'sd1, 1'b0, 1'b0, '0},
		'{32'sd0, 1'b1, 1'b0, '0},
		// ascending: no shifting at all
		'{32'sd1, 1'b0, 1'b0, '0},
		'{32'sd2, 1'b0, 1'b0, '0},
		'{32'sd3, 1'b0, 1'b0, '0},
		'{32'sd4, 1'b1, 1'b0, '0},
		// equal values must not be passed by a newer equal value
		'{32'sd7, 1'b0, 1'b0, '0},
		'{32'sd7, 1'b0, 1'b0, '0},
		'{-32'sd7, 1'b0, 1'b0, '0},
		'{32'sd7, 1'b1, 1'b0, '0},
		// extremes mixed, with the maximum twice
		'{V_MAX, 1'b0, 1'b0, '0},
		'{V_MIN, 1'b0, 1'b0, '0},
		'{32'sd0, 1'b0, 1'b0, '0},
		'{-32'sd1, 1'b0, 1'b0, '0},
		'{V_MAX, 1'b1, 1'b0, '0}
	};

	insertion_sorter_core #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_WIDTH(VALUE_WIDTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.value    (value),
		.last     (last),
		.strobe   (strobe),
		.value_res(value_res),
		.last_res (last_res),
		.overflow (overflow)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("%0t ns  ERROR %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	// Insert one value into the predicted store; on last, drain the whole
	// store in ascending order into drained and empty it.
	function automatic void insert_and_drain(input logic signed [VALUE_WIDTH-1:0] v,
			input logic is_last, ref sorted_item_t drained [$]);
		int unsigned  pos;
		sorted_item_t r;
		if (sort_fill >= MAX_ITEMS) begin
			sort_dropped = 1'b1;
		end else begin
			pos = sort_fill;
			// strictly greater entries move up; equal ones stay below
			while (pos > 0 && v < sort_store[pos-1]) begin
				sort_store[pos] = sort_store[pos-1];
				pos--;
			end
			sort_store[pos] = v;
			sort_fill++;
		end
		if (!is_last)
			return;
		for (int unsigned k = 0; k < sort_fill; k++) begin
			r.value    = sort_store[k];
			r.last_res = (k + 1 == sort_fill);
			r.overflow = sort_dropped;
			drained.push_back(r);
		end
		sort_fill    = 0;
		sort_dropped = 1'b0;
	endfunction

	// Outputs are checked before a new item is predicted, so an output and an
	// accept on the same edge cannot be mixed up.
	always @(posedge clk) begin
		sorted_item_t exp_item;
		sorted_item_t drained [$];
		dir_row_t     tag;
		if (arst_n && strobe) begin
			if (pending_sorted.size() == 0) begin
				report_mismatch($sformatf("unexpected output value=%0d last_res=%b overflow=%b",
					value_res, last_res, overflow));
			end else begin
				exp_item = pending_sorted.pop_front();
				if (value_res !== exp_item.value)
					report_mismatch($sformatf("value_res %0d, expected %0d",
						value_res, exp_item.value));
				if (last_res !== exp_item.last_res)
					report_mismatch($sformatf("last_res %b, expected %b (value %0d)",
						last_res, exp_item.last_res, exp_item.value));
				if (overflow !== exp_item.overflow)
					report_mismatch($sformatf("overflow %b, expected %b (value %0d)",
						overflow, exp_item.overflow, exp_item.value));
			end
		end
		if (arst_n && start && !busy) begin
			tag = item_tags.pop_front();
			drained.delete();
			insert_and_drain(value, last, drained);
			if (tag.known) begin
				exp_item.value    = tag.known_value;
				exp_item.last_res = 1'b1;
				exp_item.overflow = 1'b0;
				pending_sorted.push_back(exp_item);
			end else begin
				foreach (drained[i])
					pending_sorted.push_back(drained[i]);
			end
		end
	end

	function automatic int unsigned gap_len();
		int unsigned r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Mix of full-range values, a narrow band that makes duplicates, and
	// values at or near both extremes.
	function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom;
			5, 6:          return $urandom_range(0, 6) - 3;
			7:             return V_MAX - $urandom_range(0, 2);
			8:             return V_MIN + $urandom_range(0, 2);
			default:       return $urandom_range(0, 1) ? V_MAX : V_MIN;
		endcase
	endfunction

	// Called right after a rising edge. start is only lowered when a gap
	// follows, so back-to-back items keep it high without a glitch.
	task automatic send_item(input logic signed [VALUE_WIDTH-1:0] v, input logic l,
			input logic known, input logic signed [VALUE_WIDTH-1:0] known_v);
		int unsigned gap;
		dir_row_t    tag;
		gap = gap_len();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) begin
				value <= $urandom;
				last  <= 1'($urandom_range(0, 1));
				@(posedge clk);
			end
		end
		tag = '{v, l, known, known_v};
		item_tags.push_back(tag);
		start <= 1'b1;
		value <= v;
		last  <= l;
		do
			@(posedge clk);
		while (busy);
	endtask

	initial begin
		int unsigned sent;
		int unsigned set_no;
		int unsigned set_size;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_item(dir_rows[i].value, dir_rows[i].last, dir_rows[i].known,
				dir_rows[i].known_value);

		// Random sets: mostly short, a full store once, an overflowing set whose
		// last item is itself dropped once, and now and then a large set.
		sent   = 0;
		set_no = 0;
		while (sent < RAND_ITEMS) begin
			if (set_no == 3)
				set_size = MAX_ITEMS;
			else if (set_no == 7)
				set_size = MAX_ITEMS + 1;
			else if ($urandom_range(0, 39) == 0)
				set_size = $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6);
			else
				set_size = $urandom_range(1, 12);
			burst = ($urandom_range(0, 3) == 0);
			for (int unsigned k = 0; k < set_size; k++)
				send_item(pick_value(), k + 1 == set_size, 1'b0, '0);
			sent += set_size;
			set_no++;
		end
		start <= 1'b0;

		while (pending_sorted.size() != 0)
			@(posedge clk);
		repeat (MAX_ITEMS + 8) @(posedge clk);

		if (mismatch_cnt == 0) begin
			$display("insertion_sorter_core: match");
		end else begin
			$display("insertion_sorter_core: mismatch");
		end
		$finish;
	end

	// Generous ceiling, far above the slowest correct run.
	initial begin
		#5_000_000;
		$display("insertion_sorter_core: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

>>> insertion_sorter_core.f
+incdir+src
src/isort_pkg.sv
src/isort_ram.sv
src/insertion_sorter_core.sv
src/isort_checker.sv
verif/insertion_sorter_core_test.sv
